@@ src/ysf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the YMODEM sender framer.
`timescale 1ns / 1ps

package ysf_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int MAX_RESULTS = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_NAK = 8'h15;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_C   = 8'h43;

  localparam logic [1:0] FN_RESP    = 2'd0;
  localparam logic [1:0] FN_PAYLOAD = 2'd1;
  localparam logic [1:0] FN_EOF     = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_HDR_DATA   = 4'd1,
    PH_HDR_ACK    = 4'd2,
    PH_HDR_C      = 4'd3,
    PH_DATA       = 4'd4,
    PH_DATA_ACK   = 4'd5,
    PH_EOT1_NAK   = 4'd6,
    PH_EOT2_ACK   = 4'd7,
    PH_EOT2_C     = 4'd8,
    PH_CLOSE_DATA = 4'd9,
    PH_CLOSE_ACK  = 4'd10,
    PH_DONE       = 4'd11
  } phase_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ src/ysf_if.sv @@
// Valid/ready channel interfaces for input items and result beats.
`timescale 1ns / 1ps

interface ysf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface ysf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       last;
  logic [3:0] phase;
  logic       restarted;
  logic       misplaced;
  logic       finished;

  modport source (output valid, tx_byte, tx_valid, last, phase, restarted, misplaced,
                  finished, input ready);
  modport sink   (input valid, tx_byte, tx_valid, last, phase, restarted, misplaced,
                  finished, output ready);
endinterface

@@ src/ymodem_sender_framer_core.sv @@
// YMODEM sender framer: protocol sequencing, block framing and CRC-16 in one pass.
//
// Usage: "item" carries one input beat: func 0 is a receiver response byte, 1 a
// payload byte, 2 end of file. "result" carries the result beats each item causes,
// one per cycle while ready: one to four beats, the final one marked by last.
// Every beat of an item carries the same phase and status flags; tx_valid marks
// beats with a byte. The first payload byte of a block yields SOH, sequence,
// inverted sequence and the byte (four beats); the last payload byte yields the
// byte and CRC high and low (three beats); other items yield one beat.
// The first result beat is registered and shows in the cycle after the item is taken.
// Throughput: one item per cycle while each item yields one beat and result is
// ready; an item with more beats holds the input while the single result buffer
// drains one beat per ready cycle; the next item is taken as its last beat leaves.
// Reset (rst, synchronous) returns to idle with sequence, count and CRC cleared and
// drops any pending beats. When the receiver stalls, the pending beat holds and
// ready falls on the input once the buffer cannot be freed this cycle.
`timescale 1ns / 1ps

module ymodem_sender_framer_core #(
  parameter int BlockBytes = ysf_pkg::BLOCK_BYTES
) (
  input logic           clk,
  input logic           rst,
  ysf_item_if.sink      item,
  ysf_result_if.source  result
);
  import ysf_pkg::*;

  localparam int CntW = $clog2(BlockBytes);
  localparam int IdxW = $clog2(MAX_RESULTS);

  // protocol state
  phase_t          ph, ph_next;
  logic [7:0]      seq, seq_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic [15:0]     crc, crc_next;

  // result buffer
  logic [7:0]      bytes [MAX_RESULTS];
  logic [7:0]      bytes_next [MAX_RESULTS];
  logic [IdxW-1:0] n_last, n_last_next;
  logic [IdxW-1:0] idx;
  logic            busy;
  logic            has_tx, has_tx_next;
  logic            rs, rs_next;
  logic            mp, mp_next;

  logic            in_fire;
  logic            out_fire;
  logic            out_last;
  logic [7:0]      b;
  logic [15:0]     crc_base;
  logic [15:0]     crc_upd;
  logic [7:0]      want;
  phase_t          ph_ok;

  assign out_last = (idx == n_last);
  assign out_fire = busy && result.ready;
  assign item.ready = !busy || (out_last && result.ready);
  assign in_fire = item.valid && item.ready;

  always_comb begin
    ph_next     = ph;
    seq_next    = seq;
    cnt_next    = cnt;
    crc_next    = crc;
    rs_next     = 1'b0;
    mp_next     = 1'b0;
    has_tx_next = 1'b0;
    n_last_next = '0;
    for (int i = 0; i < MAX_RESULTS; i++) bytes_next[i] = 8'h00;
    b        = (ph == PH_CLOSE_DATA) ? 8'h00 : item.value;
    crc_base = (cnt == '0) ? 16'h0000 : crc;
    crc_upd  = crc_byte(crc_base, b);
    want     = SYM_ACK;
    ph_ok    = PH_DONE;

    unique case (ph)
      PH_IDLE: begin
        if (item.func == FN_RESP) begin
          if (item.value == SYM_C) begin
            ph_next  = PH_HDR_DATA;
            cnt_next = '0;
            crc_next = 16'h0000;
          end
        end else begin
          mp_next = 1'b1;
        end
      end
      PH_HDR_DATA, PH_DATA, PH_CLOSE_DATA: begin
        if (item.func == FN_PAYLOAD) begin
          has_tx_next = 1'b1;
          crc_next    = crc_upd;
          if (cnt == '0) begin
            seq_next      = (ph == PH_DATA) ? seq + 8'd1 : 8'h00;
            bytes_next[0] = SYM_SOH;
            bytes_next[1] = seq_next;
            bytes_next[2] = ~seq_next;
            bytes_next[3] = b;
            n_last_next   = IdxW'(3);
          end else if (cnt == CntW'(BlockBytes - 1)) begin
            bytes_next[0] = b;
            bytes_next[1] = crc_upd[15:8];
            bytes_next[2] = crc_upd[7:0];
            n_last_next   = IdxW'(2);
          end else begin
            bytes_next[0] = b;
          end
          if (cnt == CntW'(BlockBytes - 1)) begin
            cnt_next = '0;
            ph_next  = phase_t'(ph + 4'd1);
          end else begin
            cnt_next = cnt + CntW'(1);
          end
        end else if (item.func == FN_EOF && ph == PH_DATA && cnt == '0) begin
          has_tx_next   = 1'b1;
          bytes_next[0] = SYM_EOT;
          ph_next       = PH_EOT1_NAK;
        end else begin
          mp_next = 1'b1;
        end
      end
      PH_DONE: mp_next = 1'b1;
      default: begin
        unique case (ph)
          PH_HDR_ACK:  begin want = SYM_ACK; ph_ok = PH_HDR_C;      end
          PH_HDR_C:    begin want = SYM_C;   ph_ok = PH_DATA;       end
          PH_DATA_ACK: begin want = SYM_ACK; ph_ok = PH_DATA;       end
          PH_EOT1_NAK: begin want = SYM_NAK; ph_ok = PH_EOT2_ACK;   end
          PH_EOT2_ACK: begin want = SYM_ACK; ph_ok = PH_EOT2_C;     end
          PH_EOT2_C:   begin want = SYM_C;   ph_ok = PH_CLOSE_DATA; end
          default:     begin want = SYM_ACK; ph_ok = PH_DONE;       end
        endcase
        if (item.func != FN_RESP) begin
          mp_next = 1'b1;
        end else if (item.value == want) begin
          if (ph == PH_EOT1_NAK) begin
            has_tx_next   = 1'b1;
            bytes_next[0] = SYM_EOT;
          end
          if (ph_ok == PH_CLOSE_DATA) cnt_next = '0;
          ph_next = ph_ok;
        end else begin
          ph_next  = PH_IDLE;
          cnt_next = '0;
          crc_next = 16'h0000;
          rs_next  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      seq  <= 8'h00;
      cnt  <= '0;
      crc  <= 16'h0000;
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (in_fire) begin
        ph   <= ph_next;
        seq  <= seq_next;
        cnt  <= cnt_next;
        crc  <= crc_next;
        busy <= 1'b1;
        idx  <= '0;
      end else if (out_fire) begin
        if (out_last) busy <= 1'b0;
        else          idx  <= idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes  <= bytes_next;
      n_last <= n_last_next;
      has_tx <= has_tx_next;
      rs     <= rs_next;
      mp     <= mp_next;
    end
  end

  // result phase is the live phase: it only changes when a new item is loaded or on reset
  assign result.valid     = busy;
  assign result.tx_byte   = has_tx ? bytes[idx] : 8'h00;
  assign result.tx_valid  = has_tx;
  assign result.last      = out_last;
  assign result.phase     = ph;
  assign result.restarted = rs;
  assign result.misplaced = mp;
  assign result.finished  = (ph == PH_DONE);

endmodule
